### rtl/epma_pkg.sv
// Package for the edge period moving average block: defaults, widths and the
// sequencer state type. No dependencies; used by edge_period_moving_average.sv and dv/tb.sv.
`timescale 1ns / 1ps

package epma_pkg;

   localparam int unsigned WINDOW_DEFAULT = 10;

   localparam int unsigned TIME_WIDTH   = 64;
   localparam int unsigned PERIOD_WIDTH = 32;
   localparam int unsigned MEAN_WIDTH   = 40;
   localparam int unsigned HELD_WIDTH   = 4;
   localparam int unsigned FRAC_BITS    = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIV,
      ST_HOLD
   } seq_state_type;

endpackage

### rtl/edge_period_moving_average.sv
// Top level of the edge period moving average: sequencer, running sum and
// output register. Depends on epma_pkg, epma_ram and epma_div.
`timescale 1ns / 1ps

// Each request carries the microsecond timestamp of one rising sensor edge.
// The first request after reset only records its time and produces no
// response. Every later request forms the period since the previous edge
// (saturated to 32 bits, flagged in tuser), stores it in a ring of the last
// WINDOW periods and returns the period together with the mean of the stored
// periods in unsigned Q.8, truncated. The mean is produced by a bit-serial
// divider that yields one quotient bit per cycle while it runs. The block
// takes no new request from acceptance until the response is loaded into the
// output register; a finished response sits in the output register and the
// next request is accepted while it waits. The ring is a plain RAM with no
// reset; entries are used only after being written.

module edge_period_moving_average #(
   parameter int unsigned WINDOW = epma_pkg::WINDOW_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] edge_time

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [31:0] period_us, [71:32] mean_period_q8,
                                    // [75:72] samples_held, [79:76] zero
   output logic [0:0]  rsp_tuser    // [0] period_capped
);

   localparam int unsigned PosWidth = $clog2(WINDOW);
   localparam int unsigned CntWidth = $clog2(WINDOW + 1);
   localparam int unsigned SumWidth = epma_pkg::PERIOD_WIDTH + CntWidth;
   localparam int unsigned DivWidth = SumWidth + epma_pkg::FRAC_BITS;

   epma_pkg::seq_state_type state_ff, state_in;

   logic                              have_edge_ff, have_edge_in;
   logic [epma_pkg::TIME_WIDTH-1:0]   last_time_ff, last_time_in;
   logic [PosWidth-1:0]               pos_ff,       pos_in;
   logic [CntWidth-1:0]               fill_ff,      fill_in;
   logic [SumWidth-1:0]               sum_ff,       sum_in;
   logic [epma_pkg::PERIOD_WIDTH-1:0] period_ff,    period_in;
   logic                              capped_ff,    capped_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [epma_pkg::PERIOD_WIDTH-1:0] out_period_ff, out_period_in;
   logic [epma_pkg::MEAN_WIDTH-1:0]   out_mean_ff,   out_mean_in;
   logic [epma_pkg::HELD_WIDTH-1:0]   out_held_ff,   out_held_in;
   logic                              out_capped_ff, out_capped_in;

   logic [epma_pkg::TIME_WIDTH-1:0]   time_diff;
   logic [epma_pkg::PERIOD_WIDTH-1:0] ring_old;
   logic                              ring_wr;
   logic                              window_full;
   logic                              div_start;
   logic                              div_done;
   logic [DivWidth-1:0]               div_quotient;
   logic [CntWidth+epma_pkg::HELD_WIDTH-1:0] held_wide;
   logic                              req_fire;
   logic                              slot_free;

   assign req_fire    = req_tvalid && req_tready;
   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign time_diff   = req_tdata - last_time_ff;
   assign window_full = fill_ff == CntWidth'(WINDOW);
   // samples_held is the fill count masked to four bits
   assign held_wide   = {{epma_pkg::HELD_WIDTH{1'b0}}, fill_ff};

   epma_ram #(
      .WIDTH (epma_pkg::PERIOD_WIDTH),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (pos_ff),
      .wr_data (period_ff),
      .rd_addr (pos_ff),
      .rd_data (ring_old)
   );

   // the divider loads the sum and fill count as they are being committed
   epma_div #(
      .DIVIDEND_WIDTH (DivWidth),
      .DIVISOR_WIDTH  (CntWidth)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_in, {epma_pkg::FRAC_BITS{1'b0}}}),
      .divisor  (fill_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      have_edge_in  = have_edge_ff;
      last_time_in  = last_time_ff;
      pos_in        = pos_ff;
      fill_in       = fill_ff;
      sum_in        = sum_ff;
      period_in     = period_ff;
      capped_in     = capped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_period_in = out_period_ff;
      out_mean_in   = out_mean_ff;
      out_held_in   = out_held_ff;
      out_capped_in = out_capped_ff;
      ring_wr       = 1'b0;
      div_start     = 1'b0;
      req_tready    = 1'b0;

      unique case (state_ff)
         epma_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               last_time_in = req_tdata;
               have_edge_in = 1'b1;
               // first edge only records its time
               if (have_edge_ff) begin
                  capped_in = time_diff[epma_pkg::TIME_WIDTH-1:epma_pkg::PERIOD_WIDTH] != '0;
                  period_in = capped_in ? '1 : time_diff[epma_pkg::PERIOD_WIDTH-1:0];
                  state_in  = epma_pkg::ST_READ;
               end
            end
         end
         epma_pkg::ST_READ: begin
            // ring read of the oldest entry lands next cycle
            state_in = epma_pkg::ST_UPDATE;
         end
         epma_pkg::ST_UPDATE: begin
            ring_wr = 1'b1;
            if (window_full) begin
               sum_in = sum_ff - SumWidth'(ring_old) + SumWidth'(period_ff);
            end else begin
               sum_in  = sum_ff + SumWidth'(period_ff);
               fill_in = fill_ff + CntWidth'(1);
            end
            pos_in    = (pos_ff == PosWidth'(WINDOW - 1)) ? '0 : pos_ff + PosWidth'(1);
            // kick the divider with the new sum and fill count
            div_start = 1'b1;
            state_in  = epma_pkg::ST_DIV;
         end
         epma_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = epma_pkg::ST_HOLD;
            end
         end
         epma_pkg::ST_HOLD: begin
            // load the output register once the previous response is gone
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               out_period_in = period_ff;
               out_mean_in   = div_quotient[epma_pkg::MEAN_WIDTH-1:0];
               out_held_in   = held_wide[epma_pkg::HELD_WIDTH-1:0];
               out_capped_in = capped_ff;
               state_in      = epma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = epma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= epma_pkg::ST_IDLE;
         have_edge_ff <= 1'b0;
         last_time_ff <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_edge_ff <= have_edge_in;
         last_time_ff <= last_time_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff     <= period_in;
      capped_ff     <= capped_in;
      out_period_ff <= out_period_in;
      out_mean_ff   <= out_mean_in;
      out_held_ff   <= out_held_in;
      out_capped_ff <= out_capped_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {4'b0000, out_held_ff, out_mean_ff, out_period_ff};
   assign rsp_tuser[0] = out_capped_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntWidth'(WINDOW))
      else $error("fill count beyond window");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff < PosWidth'(WINDOW) || WINDOW == (1 << PosWidth))
      else $error("ring position beyond window");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == epma_pkg::ST_DIV)
      else $error("divider finished outside the divide step");

   a_rsp_has_samples: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> fill_ff != '0 && have_edge_ff)
      else $error("response without a stored period");

   a_full_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      window_full && state_ff == epma_pkg::ST_UPDATE |=> window_full)
      else $error("fill count dropped after window filled");
`endif

endmodule

### rtl/epma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the period ring of the edge period moving average.
`timescale 1ns / 1ps

module epma_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/epma_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// No dependencies; used by the edge period moving average top level.
`timescale 1ns / 1ps

module epma_div #(
   parameter int unsigned DIVIDEND_WIDTH = 44,
   parameter int unsigned DIVISOR_WIDTH  = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic                      done,
   output logic [DIVIDEND_WIDTH-1:0] quotient
);

   localparam int unsigned CountWidth = $clog2(DIVIDEND_WIDTH + 1);

   logic                      busy_ff,  busy_in;
   logic                      done_ff,  done_in;
   logic [CountWidth-1:0]     count_ff, count_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff,   rem_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff,   quo_in;
   logic [DIVISOR_WIDTH-1:0]  dvs_ff,   dvs_in;

   logic [DIVISOR_WIDTH:0]    trial;
   logic [DIVISOR_WIDTH:0]    trial_diff;
   logic                      fits;

   assign trial      = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
   assign fits       = trial >= {1'b0, dvs_ff};
   assign trial_diff = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CountWidth'(DIVIDEND_WIDTH);
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in   = fits ? trial_diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         quo_in   = {quo_ff[DIVIDEND_WIDTH-2:0], fits};
         count_in = count_ff - CountWidth'(1);
         if (count_ff == CountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### dv/tb.sv
// Self-checking bench for edge_period_moving_average: drives edge timestamps,
// predicts period, Q.8 mean, fill level and cap flag. Depends on epma_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned WINDOW      = epma_pkg::WINDOW_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned DRAIN_TAIL  = 60;    // idle tail after the last response is back
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned PHASE_ITEMS = 106;
   localparam int unsigned PRINT_CAP   = 30;

   // One expected response, fields as the block reports them.
   typedef struct packed {
      logic [31:0] period;
      logic [39:0] mean_q8;
      logic [3:0]  held;
      logic        capped;
   } edge_result_type;

   // Tracks the window state on its own and queues one expectation per period.
   class edge_period_board;
      logic            edge_seen;
      logic [63:0]     prev_time;
      logic [31:0]     period_hist [WINDOW];
      int unsigned     slot;
      int unsigned     count;
      logic [63:0]     total;
      edge_result_type expected_q [$];
      int unsigned     mismatches;
      int unsigned     checked;
      int unsigned     capped_seen;
      int unsigned     wraps_seen;

      function new();
         edge_seen   = 1'b0;
         prev_time   = '0;
         slot        = 0;
         count       = 0;
         total       = '0;
         mismatches  = 0;
         checked     = 0;
         capped_seen = 0;
         wraps_seen  = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Note one accepted timestamp and predict what it produces.
      function void note_request(logic [63:0] stamp);
         logic [63:0]     diff;
         logic [63:0]     scaled;
         edge_result_type exp_rsp;
         if (!edge_seen) begin
            // first edge only arms the timer
            edge_seen = 1'b1;
            prev_time = stamp;
            return;
         end
         diff      = stamp - prev_time;
         prev_time = stamp;
         exp_rsp.capped = (diff > 64'h0000_0000_FFFF_FFFF);
         exp_rsp.period = exp_rsp.capped ? 32'hFFFF_FFFF : diff[31:0];
         if (exp_rsp.capped) capped_seen++;
         if (count >= WINDOW) begin
            // full window: retire the oldest period
            total = total - {32'd0, period_hist[slot]};
            wraps_seen++;
         end else begin
            count++;
         end
         period_hist[slot] = exp_rsp.period;
         total = total + {32'd0, exp_rsp.period};
         slot  = (slot >= WINDOW - 1) ? 0 : slot + 1;
         scaled          = (total << 8) / count;
         exp_rsp.mean_q8 = scaled[39:0];
         exp_rsp.held    = count[3:0];
         expected_q.push_back(exp_rsp);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         if (mismatches < PRINT_CAP)
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
         mismatches++;
      endtask

      // Compare one accepted response with the oldest expectation.
      task check_response(logic [79:0] data, logic [0:0] user);
         edge_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response", data[63:0], '0);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (data[31:0] !== want.period)
            report_mismatch("period_us", data[31:0], want.period);
         if (data[71:32] !== want.mean_q8)
            report_mismatch("mean_period_q8", data[71:32], want.mean_q8);
         if (data[75:72] !== want.held)
            report_mismatch("samples_held", data[75:72], want.held);
         if (user[0] !== want.capped)
            report_mismatch("period_capped", user[0], want.capped);
      endtask

      task close_out();
         while (expected_q.size() != 0) begin
            report_mismatch("missing response", expected_q[0].period, '0);
            void'(expected_q.pop_front());
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // [63:0] edge_time
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;    // [31:0] period_us, [71:32] mean_period_q8,
                              // [75:72] samples_held, [79:76] zero
   logic [0:0]  rsp_tuser;    // [0] period_capped

   edge_period_board board;
   int unsigned      send_idle_pct;
   int unsigned      recv_stall_pct;
   logic             hold_due;
   int unsigned      hold_left;
   int unsigned      cycle_count;
   int unsigned      edges_sent;
   logic [63:0]      last_stamp;

   edge_period_moving_average #(
      .WINDOW(WINDOW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hard stop in case the block hangs.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still due",
                  cycle_count, board.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side: check on handshake, then pick next cycle's ready.
   // A pending long hold is counted down here, independent of the sender.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata, rsp_tuser);
         if (hold_due) begin
            hold_left = LONG_HOLD;
            hold_due  = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Offer one timestamp, idling at random first; leave tvalid high on return.
   task automatic send_edge(input logic [63:0] stamp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(stamp);
      last_stamp = stamp;
      edges_sent++;
   endtask

   // Drop tvalid and wait until every predicted response has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // Mostly plausible sensor periods, with saturation edges, repeats,
   // backward jumps and fully random timestamps mixed in.
   function automatic logic [63:0] next_stamp(input logic [63:0] prev);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)      return prev + $urandom_range(1, 5000);
      else if (pick < 72) return prev + {32'd0, $urandom};
      else if (pick < 78) return prev + 64'h0000_0000_FFFF_FFFF + $urandom_range(0, 1);
      else if (pick < 84) return prev;
      else if (pick < 91) return prev + {$urandom_range(1, 255), $urandom};
      else if (pick < 95) return prev - $urandom_range(1, 1000);
      else                return {$urandom, $urandom};
   endfunction

   initial begin
      int unsigned phase;
      int unsigned n;
      board          = new();
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_due       = 1'b0;
      hold_left      = 0;
      edges_sent     = 0;
      last_stamp     = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero time as the first edge, equal stamps, exact 32-bit
      // boundary, overflow, time running backward, wrap past 2^64.
      send_edge(64'd0);
      send_edge(64'd0);
      send_edge(64'd1);
      send_edge(64'h0000_0001_0000_0000);
      send_edge(64'h0000_0002_0000_0000);
      send_edge(64'd5);
      send_edge(64'hFFFF_FFFF_FFFF_FFF0);
      send_edge(64'h0000_0000_0000_000F);
      // Run the window full of maximum periods and past the wrap.
      for (n = 0; n < 12; n++)
         send_edge(last_stamp + 64'h0000_0000_FFFF_FFFF);
      send_edge(last_stamp);
      send_edge(last_stamp);
      send_edge(last_stamp + 64'd3);
      drain_responses();

      // Random: four idling profiles, a pressure burst in the receiver-stalled phase.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 57; recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 57;
            end
            default: begin
               send_idle_pct = 33; recv_stall_pct = 33;
            end
         endcase
         if (phase == 2) begin
            // hold the receiver off while requests keep coming
            hold_due = 1'b1;
            for (n = 0; n < 12; n++)
               send_edge(next_stamp(last_stamp));
         end
         for (n = 0; n < PHASE_ITEMS; n++)
            send_edge(next_stamp(last_stamp));
         drain_responses();
      end

      board.close_out();
      $display("Sent %0d edges, checked %0d responses (%0d capped, %0d window wraps)",
               edges_sent, board.checked, board.capped_seen, board.wraps_seen);
      $display("Idle profiles: none, sender, receiver with long hold, both");
      if (board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/epma_pkg.sv
rtl/epma_ram.sv
rtl/epma_div.sv
rtl/edge_period_moving_average.sv
dv/tb.sv
